// ===== rtl/fpbc_pkg.sv =====
// Package for the frustum plane builder and box culler.
// Holds shared constants, types, plane/corner lookup functions and a saturation helper; no dependencies.
package fpbc_pkg;

    localparam int unsigned FracBitsDef = 16;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_TEST = 1'b1
    } t_func;

    typedef struct packed {
        logic        func;
        logic [1:0]  column_index;
        logic [31:0] d0;
        logic [31:0] d1;
        logic [31:0] d2;
        logic [31:0] d3;
        logic [31:0] d4;
        logic [31:0] d5;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SQ,
        ST_SQRT,
        ST_NORM,
        ST_CROSS,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_BOUND,
        ST_TEST,
        ST_OUT
    } t_state;

    function automatic logic [1:0] plane_row(input logic [2:0] p);
        logic [1:0] r;
        begin
            r = p[2:1];
            return r;
        end
    endfunction

    function automatic logic plane_neg(input logic [2:0] p);
        logic n;
        begin
            n = p[0] ^ p[1];
            return n;
        end
    endfunction

    function automatic logic [2:0] corner_plane(input logic [2:0] c, input logic [1:0] j);
        logic [2:0] r;
        begin
            unique case (j)
                2'd0: r = {2'b00, c[0]};
                2'd1: r = c[1] ? 3'd2 : 3'd3;
                default: r = c[2] ? 3'd5 : 3'd4;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sh0_7FFF_FFFF) begin
                r = 32'sh7FFF_FFFF;
            end else if (v < -66'sh0_8000_0000) begin
                r = 32'sh8000_0000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/fpbc_front.sv =====
// Front end: accepts transactions and holds them in a short queue.
// Depends on fpbc_pkg.
module fpbc_front
    import fpbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop,
    output t_cmd        o_cmd
);
    t_cmd       r_q [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready     = (r_cnt != 2'(QueueDepth));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/fpbc_div.sv =====
// Radix-2 signed divider: quotient = num / den truncated toward zero.
// Standalone unit, one quotient bit per cycle; depends on fpbc_pkg.
module fpbc_div
    import fpbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [65:0] o_quo
);
    logic [63:0] r_rem, r_q, r_d;
    logic        r_neg, r_busy;
    logic [6:0]  r_cnt;
    logic [64:0] trial;
    logic [63:0] shifted;

    assign shifted = {r_rem[62:0], r_q[63]};
    assign trial   = {1'b0, shifted} - {1'b0, r_d};
    assign o_quo   = r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num[63] ? 64'(-i_num) : i_num;
            r_d   <= i_den[63] ? 64'(-i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            if (!trial[64]) begin
                r_rem <= trial[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/fpbc_back.sv =====
// Back end: matrix and plane storage, plane rebuild sequencer and box test.
// Depends on fpbc_pkg and fpbc_div.
module fpbc_back
    import fpbc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FracBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  t_cmd               i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_inside_res,
    output logic               o_bounds_valid,
    output logic signed [31:0] o_bound [6]
);
    t_state             r_st, n_st;
    logic signed [31:0] r_m [16];
    logic signed [31:0] r_pl [24];
    logic signed [31:0] r_cs [9];
    logic signed [31:0] r_co [24];
    logic signed [31:0] r_bd [6];
    logic [2:0]         r_p, r_c;
    logic [1:0]         r_k;
    logic [63:0]        r_ss;
    logic [63:0]        r_x, r_r, r_bit;
    logic [31:0]        r_mag;
    logic signed [65:0] r_acc;
    logic signed [31:0] r_den;
    logic               r_inside, r_bvalid, r_divgo;
    logic               div_done;
    logic signed [65:0] div_q;
    logic signed [63:0] div_num, div_den;
    logic [3:0]         r_j;

    logic signed [31:0] ma, mb, pa, pb, pc, pd;
    logic signed [63:0] prod, prod2;
    logic signed [65:0] fl, fl2;
    logic [2:0]         q0, q1, q2;
    logic signed [31:0] bsel, nsel;

    function automatic logic signed [65:0] fshift(input logic signed [65:0] v);
        return v >>> FRAC_BITS;
    endfunction

    assign q0 = corner_plane(r_c, 2'd0);
    assign q1 = corner_plane(r_c, 2'd1);
    assign q2 = corner_plane(r_c, 2'd2);

    always_comb begin
        pa = '0;
        pb = '0;
        pc = '0;
        pd = '0;
        // r_j: 0..2 c23, 3..5 c31, 6..8 c12 component cross products.
        case (r_j)
            4'd0: begin pa = r_pl[{q1, 2'd1}]; pb = r_pl[{q2, 2'd2}];
                        pc = r_pl[{q1, 2'd2}]; pd = r_pl[{q2, 2'd1}]; end
            4'd1: begin pa = r_pl[{q1, 2'd2}]; pb = r_pl[{q2, 2'd0}];
                        pc = r_pl[{q1, 2'd0}]; pd = r_pl[{q2, 2'd2}]; end
            4'd2: begin pa = r_pl[{q1, 2'd0}]; pb = r_pl[{q2, 2'd1}];
                        pc = r_pl[{q1, 2'd1}]; pd = r_pl[{q2, 2'd0}]; end
            4'd3: begin pa = r_pl[{q2, 2'd1}]; pb = r_pl[{q0, 2'd2}];
                        pc = r_pl[{q2, 2'd2}]; pd = r_pl[{q0, 2'd1}]; end
            4'd4: begin pa = r_pl[{q2, 2'd2}]; pb = r_pl[{q0, 2'd0}];
                        pc = r_pl[{q2, 2'd0}]; pd = r_pl[{q0, 2'd2}]; end
            4'd5: begin pa = r_pl[{q2, 2'd0}]; pb = r_pl[{q0, 2'd1}];
                        pc = r_pl[{q2, 2'd1}]; pd = r_pl[{q0, 2'd0}]; end
            4'd6: begin pa = r_pl[{q0, 2'd1}]; pb = r_pl[{q1, 2'd2}];
                        pc = r_pl[{q0, 2'd2}]; pd = r_pl[{q1, 2'd1}]; end
            4'd7: begin pa = r_pl[{q0, 2'd2}]; pb = r_pl[{q1, 2'd0}];
                        pc = r_pl[{q0, 2'd0}]; pd = r_pl[{q1, 2'd2}]; end
            default: begin pa = r_pl[{q0, 2'd0}]; pb = r_pl[{q1, 2'd1}];
                        pc = r_pl[{q0, 2'd1}]; pd = r_pl[{q1, 2'd0}]; end
        endcase
    end

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_st)
            ST_SQ: begin
                ma = r_pl[{r_p, r_k}];
                mb = r_pl[{r_p, r_k}];
            end
            ST_DEN: begin
                ma = r_pl[{q0, r_k}];
                mb = r_cs[4'(r_k)];
            end
            ST_NUM: begin
                ma = r_pl[{corner_plane(r_c, r_k), 2'd3}];
                mb = r_cs[4'(r_k) * 4'd3 + 4'(r_j)];
            end
            default: begin
                ma = r_pl[{r_p, r_k}];
                mb = bsel;
            end
        endcase
    end

    always_comb begin
        nsel = r_pl[{r_p, r_k}];
        unique case (r_k)
            2'd0: bsel = nsel[31] ? $signed(i_cmd.d0) : $signed(i_cmd.d3);
            2'd1: bsel = nsel[31] ? $signed(i_cmd.d1) : $signed(i_cmd.d4);
            default: bsel = nsel[31] ? $signed(i_cmd.d2) : $signed(i_cmd.d5);
        endcase
    end

    assign prod  = ma * mb;
    assign prod2 = pa * pb - pc * pd;
    assign fl    = fshift(66'(prod));
    assign fl2   = fshift(66'(prod2));

    always_comb begin
        div_num = '0;
        div_den = '0;
        if (r_st == ST_NORM) begin
            div_num = 64'(r_pl[{r_p, r_k}]) <<< FRAC_BITS;
            div_den = 64'(r_mag);
        end else begin
            div_num = 64'($signed(r_acc[31:0])) <<< FRAC_BITS;
            div_den = 64'(r_den);
        end
    end

    fpbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_divgo),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign o_cmd_pop = (r_st == ST_OUT) && i_ready;
    assign o_valid   = (r_st == ST_OUT);
    assign o_inside_res   = r_inside;
    assign o_bounds_valid = r_bvalid;
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            o_bound[i] = r_bvalid ? r_bd[i] : 32'sd0;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_cmd_valid) begin
                n_st = (i_cmd.func == FUNC_TEST) ? ST_TEST :
                       (i_cmd.column_index == 2'd3) ? ST_BUILD : ST_OUT;
            end
            ST_BUILD: if (r_p == 3'd5 && r_k == 2'd3) n_st = ST_SQ;
            ST_SQ:    if (r_k == 2'd2) n_st = ST_SQRT;
            ST_SQRT:  if (r_bit == 64'd0) n_st = ST_NORM;
            ST_NORM:  if (r_mag <= 32'd1 || (div_done && r_k == 2'd3)) begin
                n_st = (r_p == 3'd5) ? ST_CROSS : ST_SQ;
            end
            ST_CROSS: if (r_j == 4'd8) n_st = ST_DEN;
            ST_DEN:   if (r_k == 2'd3) n_st = ST_NUM;
            ST_NUM:   if (r_k == 2'd3) n_st = ST_DIV;
            ST_DIV:   if (r_den == 0 || div_done) begin
                n_st = (r_j != 4'd2) ? ST_NUM : (r_c == 3'd7) ? ST_BOUND : ST_CROSS;
            end
            ST_BOUND: if (r_c == 3'd7) n_st = ST_OUT;
            ST_TEST:  if (r_k == 2'd3 && (r_p == 3'd5 || r_acc < 0)) n_st = ST_OUT;
            ST_OUT:   if (i_ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_divgo  <= 1'b0;
            r_inside <= 1'b0;
            r_bvalid <= 1'b0;
            r_p      <= '0;
            r_k      <= '0;
            r_c      <= '0;
            r_j      <= '0;
            for (int i = 0; i < 16; i++) r_m[i] <= '0;
            for (int i = 0; i < 24; i++) r_pl[i] <= '0;
        end else begin
            r_st    <= n_st;
            r_divgo <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_cmd_valid) begin
                    r_p <= '0;
                    r_k <= '0;
                    r_c <= '0;
                    r_j <= '0;
                    r_inside <= 1'b0;
                    r_bvalid <= 1'b0;
                    if (i_cmd.func == FUNC_LOAD) begin
                        r_acc <= '0;
                        r_m[{i_cmd.column_index, 2'd0}] <= i_cmd.d0;
                        r_m[{i_cmd.column_index, 2'd1}] <= i_cmd.d1;
                        r_m[{i_cmd.column_index, 2'd2}] <= i_cmd.d2;
                        r_m[{i_cmd.column_index, 2'd3}] <= i_cmd.d3;
                    end else begin
                        r_acc <= 66'(r_pl[3]);
                    end
                end
                ST_BUILD: begin
                    r_pl[{r_p, r_k}] <= sat32(plane_neg(r_p) ?
                        66'(r_m[{r_k, 2'd3}]) - 66'(r_m[{r_k, plane_row(r_p)}]) :
                        66'(r_m[{r_k, 2'd3}]) + 66'(r_m[{r_k, plane_row(r_p)}]));
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_p <= (r_p == 3'd5) ? 3'd0 : r_p + 3'd1;
                    end
                    r_ss <= '0;
                end
                ST_SQ: begin
                    r_ss <= r_ss + 64'(prod);
                    r_k  <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    r_bit <= 64'd1 << 62;
                    r_r  <= '0;
                    r_x  <= r_ss + 64'(prod);
                end
                ST_SQRT: begin
                    if (r_bit > r_x && r_r == 64'd0) begin
                        r_bit <= r_bit >> 2;
                    end else if (r_bit != 64'd0) begin
                        if (r_x >= r_r + r_bit) begin
                            r_x <= r_x - (r_r + r_bit);
                            r_r <= (r_r >> 1) + r_bit;
                        end else begin
                            r_r <= r_r >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                    r_mag <= r_r[31:0];
                    if (r_bit == 64'd0) begin
                        r_divgo <= (r_r > 64'd1);
                        r_k <= '0;
                    end
                end
                ST_NORM: begin
                    if (r_mag <= 32'd1 || (div_done && r_k == 2'd3)) begin
                        if (r_mag > 32'd1) r_pl[{r_p, r_k}] <= sat32(div_q);
                        r_k <= '0;
                        r_p <= r_p + 3'd1;
                        r_ss <= '0;
                        r_j <= '0;
                        r_c <= '0;
                    end else if (div_done) begin
                        r_pl[{r_p, r_k}] <= sat32(div_q);
                        r_k <= r_k + 2'd1;
                        r_divgo <= 1'b1;
                    end
                end
                ST_CROSS: begin
                    r_cs[r_j] <= sat32(fl2);
                    r_j <= (r_j == 4'd8) ? 4'd0 : r_j + 4'd1;
                    r_k <= '0;
                    r_acc <= '0;
                end
                ST_DEN: begin
                    if (r_k == 2'd3) begin
                        r_den <= sat32(r_acc);
                        r_k <= '0;
                        r_acc <= '0;
                    end else begin
                        r_acc <= r_acc + fl;
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_NUM: begin
                    if (r_k == 2'd3) begin
                        r_acc <= 66'(sat32(r_acc));
                        r_divgo <= (r_den != 0);
                        r_k <= '0;
                    end else begin
                        r_acc <= r_acc + fl;
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_DIV: if (r_den == 0 || div_done) begin
                    r_co[5'(r_c) * 5'd3 + 5'(r_j)] <= (r_den == 0) ? 32'sd0 : sat32(-div_q);
                    r_acc <= '0;
                    r_j <= (r_j == 4'd2) ? 4'd0 : r_j + 4'd1;
                    if (r_j == 4'd2) r_c <= (r_c == 3'd7) ? 3'd0 : r_c + 3'd1;
                end
                ST_BOUND: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_c == 3'd0) begin
                            r_bd[k] <= r_co[k];
                            r_bd[3+k] <= r_co[k];
                        end else begin
                            if (r_co[5'(r_c)*5'd3+5'(k)] < r_bd[k])
                                r_bd[k] <= r_co[5'(r_c)*5'd3+5'(k)];
                            if (r_co[5'(r_c)*5'd3+5'(k)] > r_bd[3+k])
                                r_bd[3+k] <= r_co[5'(r_c)*5'd3+5'(k)];
                        end
                    end
                    r_c <= r_c + 3'd1;
                    r_bvalid <= 1'b1;
                end
                ST_TEST: begin
                    if (r_k == 2'd3) begin
                        r_inside <= (r_acc >= 0);
                        r_k <= '0;
                        r_p <= r_p + 3'd1;
                        r_acc <= 66'(r_pl[{r_p + 3'd1, 2'd3}]);
                    end else begin
                        r_acc <= r_acc + fl;
                        r_k <= r_k + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/frustum_plane_build_and_box_cull.sv =====
// Top level of the frustum plane builder and box culler.
// Depends on fpbc_pkg, fpbc_front and fpbc_back.
//
//  Channel  Direction  Handshake
//  input    in         i_valid / o_ready, fields i_func .. i_box_max_z
//  output   out        o_valid / i_ready, fields o_inside_res .. o_bound_max_z
//
// A column-3 load rebuilds planes with a 64-step serial divider, which is
// skipped for planes or corners that need no division; other loads only
// store the column.
// Reset clears the matrix and planes at once; a two-entry queue lets input
// transactions enter while a result waits on the output.
module frustum_plane_build_and_box_cull
    import fpbc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FracBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [1:0]         i_column_index,
    input  logic signed [31:0] i_col_row0,
    input  logic signed [31:0] i_col_row1,
    input  logic signed [31:0] i_col_row2,
    input  logic signed [31:0] i_col_row3,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_inside_res,
    output logic               o_bounds_valid,
    output logic signed [31:0] o_bound_min_x,
    output logic signed [31:0] o_bound_min_y,
    output logic signed [31:0] o_bound_min_z,
    output logic signed [31:0] o_bound_max_x,
    output logic signed [31:0] o_bound_max_y,
    output logic signed [31:0] o_bound_max_z
);
    t_cmd               in_cmd, q_cmd;
    logic               q_valid, q_pop;
    logic signed [31:0] bd [6];

    always_comb begin
        in_cmd.func         = i_func;
        in_cmd.column_index = i_column_index;
        if (i_func == FUNC_TEST) begin
            in_cmd.d0 = i_box_min_x;
            in_cmd.d1 = i_box_min_y;
            in_cmd.d2 = i_box_min_z;
            in_cmd.d3 = i_box_max_x;
            in_cmd.d4 = i_box_max_y;
            in_cmd.d5 = i_box_max_z;
        end else begin
            in_cmd.d0 = i_col_row0;
            in_cmd.d1 = i_col_row1;
            in_cmd.d2 = i_col_row2;
            in_cmd.d3 = i_col_row3;
            in_cmd.d4 = '0;
            in_cmd.d5 = '0;
        end
    end

    fpbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (in_cmd),
        .o_cmd_valid (q_valid),
        .i_cmd_pop   (q_pop),
        .o_cmd       (q_cmd)
    );

    fpbc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_pop      (q_pop),
        .i_cmd          (q_cmd),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_inside_res   (o_inside_res),
        .o_bounds_valid (o_bounds_valid),
        .o_bound        (bd)
    );

    assign o_bound_min_x = bd[0];
    assign o_bound_min_y = bd[1];
    assign o_bound_min_z = bd[2];
    assign o_bound_max_x = bd[3];
    assign o_bound_max_y = bd[4];
    assign o_bound_max_z = bd[5];
endmodule
